### design/smmf_pkg.sv
// Shared constants and types for the set maximum and mode finder.
// No dependencies; imported by every module of the block.
package smmf_pkg;

   localparam int DATA_W       = 32;
   localparam int COUNT_W      = 5;
   localparam int CAPACITY_DEF = 16;

   // evaluation sequencer states
   typedef enum logic [1:0] {
      EV_IDLE,
      EV_SCAN,
      EV_EMIT
   } eval_state_type;

   // control from the sequencer to the element store
   typedef struct packed {
      logic rd_en;
      logic clear;
   } store_ctl_type;

endpackage

### design/smmf_store.sv
// Element store: the set memory, its fill level and the dropped-word flag.
// Depends on smmf_pkg.
module smmf_store
   import smmf_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [DATA_W-1:0] wr_data,
   input  store_ctl_type     ctl,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data,
   output logic [CW-1:0]     fill,
   output logic              dropped
);

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;
   logic [CW-1:0]     fill_ff, fill_in;
   logic              dropped_ff, dropped_in;
   logic              room;

   assign room = (fill_ff < CW'(CAPACITY));

   always_comb begin
      fill_in    = fill_ff;
      dropped_in = dropped_ff;
      if (ctl.clear) begin
         fill_in    = '0;
         dropped_in = 1'b0;
      end else if (wr_en) begin
         if (room) begin
            fill_in = fill_ff + 1'b1;
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         dropped_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         dropped_ff <= dropped_in;
      end
   end

   // single write port (loading), single registered read port (evaluation)
   always_ff @(posedge clock) begin
      if (wr_en && room && !ctl.clear) begin
         mem[fill_ff[AW-1:0]] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign fill    = fill_ff;
   assign dropped = dropped_ff;

endmodule

### design/smmf_eval.sv
// Evaluation sequencer: pairwise occurrence scan, occurrence memory, maximum
// tracking and the registered result word. Depends on smmf_pkg.
module smmf_eval
   import smmf_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  logic [CW-1:0]            fill,
   input  logic                     dropped,
   input  logic [DATA_W-1:0]        rd_data,
   output store_ctl_type            ctl,
   output logic [AW-1:0]            rd_addr,
   output logic                     busy,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_mode_value,
   output logic [COUNT_W-1:0]       rsp_mode_count,
   output logic signed [DATA_W-1:0] rsp_max_value,
   output logic [COUNT_W-1:0]       rsp_max_count,
   output logic                     rsp_overflow,
   output logic                     rsp_last_res
);

   eval_state_type    state_ff, state_in;
   logic [CW-1:0]     i_ff, i_in, j_ff, j_in, e_ff, e_in;
   logic              pend_ff, pend_in, first_ff, first_in, end_ff, end_in;
   logic [AW-1:0]     pend_i_ff, pend_i_in;
   logic [CW-1:0]     cnt_ff, cnt_in, cnt_fin;
   logic [DATA_W-1:0] vi_ff, vi_in, maxv_ff, maxv_in;
   logic [CW-1:0]     maxc_ff, maxc_in, best_ff, best_in;
   logic [AW-1:0]     last_idx_ff, last_idx_in;
   logic [CW-1:0]     last_pos;
   logic              pend_is_last;

   logic [CW-1:0]     occ_mem [CAPACITY];
   logic [CW-1:0]     occ_rd_ff;
   logic              occ_we, occ_re;

   logic                     strobe_ff, strobe_in;
   logic [DATA_W-1:0]        mode_v_ff, mode_v_in;
   logic [COUNT_W-1:0]       mode_c_ff, mode_c_in;
   logic [DATA_W-1:0]        max_v_ff, max_v_in;
   logic [COUNT_W-1:0]       max_c_ff, max_c_in;
   logic                     ovf_ff, ovf_in, lres_ff, lres_in;

   assign last_pos     = fill - 1'b1;
   assign pend_is_last = (CW'(pend_i_ff) == last_pos);
   assign cnt_fin      = first_ff ? CW'(1) : cnt_ff + CW'(rd_data == vi_ff);

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      e_in        = e_ff;
      pend_in     = 1'b0;
      first_in    = first_ff;
      end_in      = end_ff;
      pend_i_in   = pend_i_ff;
      cnt_in      = cnt_ff;
      vi_in       = vi_ff;
      maxv_in     = maxv_ff;
      maxc_in     = maxc_ff;
      best_in     = best_ff;
      last_idx_in = last_idx_ff;
      occ_we      = 1'b0;
      occ_re      = 1'b0;
      ctl         = '{rd_en: 1'b0, clear: 1'b0};
      rd_addr     = j_ff[AW-1:0];
      strobe_in   = 1'b0;
      mode_v_in   = mode_v_ff;
      mode_c_in   = mode_c_ff;
      max_v_in    = max_v_ff;
      max_c_in    = max_c_ff;
      ovf_in      = ovf_ff;
      lres_in     = lres_ff;

      case (state_ff)
         EV_IDLE: begin
            if (go) begin
               state_in = EV_SCAN;
               i_in     = '0;
               j_in     = '0;
               best_in  = '0;
            end
         end

         EV_SCAN: begin
            // issue: row i, column j running from i to the last element
            if (i_ff < fill) begin
               ctl.rd_en = 1'b1;
               pend_in   = 1'b1;
               first_in  = (j_ff == i_ff);
               end_in    = (j_ff == last_pos);
               pend_i_in = i_ff[AW-1:0];
               if (j_ff == last_pos) begin
                  i_in = i_ff + 1'b1;
                  j_in = i_ff + 1'b1;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
            // process the word read last cycle
            if (pend_ff) begin
               cnt_in = cnt_fin;
               if (first_ff) begin
                  vi_in = rd_data;
                  if (pend_i_ff == '0) begin
                     maxv_in = rd_data;
                     maxc_in = CW'(1);
                  end else if ($signed(rd_data) > $signed(maxv_ff)) begin
                     maxv_in = rd_data;
                     maxc_in = CW'(1);
                  end else if (rd_data == maxv_ff) begin
                     maxc_in = maxc_ff + 1'b1;
                  end
               end
               if (end_ff) begin
                  occ_we = 1'b1;
                  if (cnt_fin > best_ff) begin
                     best_in     = cnt_fin;
                     last_idx_in = pend_i_ff;
                  end else if (cnt_fin == best_ff) begin
                     last_idx_in = pend_i_ff;
                  end
                  if (pend_is_last) begin
                     state_in = EV_EMIT;
                     e_in     = '0;
                  end
               end
            end
         end

         EV_EMIT: begin
            rd_addr = e_ff[AW-1:0];
            if (e_ff < fill) begin
               ctl.rd_en = 1'b1;
               occ_re    = 1'b1;
               pend_in   = 1'b1;
               pend_i_in = e_ff[AW-1:0];
               e_in      = e_ff + 1'b1;
            end
            if (pend_ff) begin
               if (occ_rd_ff == best_ff) begin
                  strobe_in = 1'b1;
                  mode_v_in = rd_data;
                  mode_c_in = COUNT_W'(occ_rd_ff);
                  max_v_in  = maxv_ff;
                  max_c_in  = COUNT_W'(maxc_ff);
                  ovf_in    = dropped;
                  lres_in   = (pend_i_ff == last_idx_ff);
               end
               if (pend_is_last) begin
                  ctl.clear = 1'b1;
                  state_in  = EV_IDLE;
               end
            end
         end

         default: begin
            state_in = EV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= EV_IDLE;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      e_ff        <= e_in;
      first_ff    <= first_in;
      end_ff      <= end_in;
      pend_i_ff   <= pend_i_in;
      cnt_ff      <= cnt_in;
      vi_ff       <= vi_in;
      maxv_ff     <= maxv_in;
      maxc_ff     <= maxc_in;
      best_ff     <= best_in;
      last_idx_ff <= last_idx_in;
      mode_v_ff   <= mode_v_in;
      mode_c_ff   <= mode_c_in;
      max_v_ff    <= max_v_in;
      max_c_ff    <= max_c_in;
      ovf_ff      <= ovf_in;
      lres_ff     <= lres_in;
   end

   // occurrence memory: written during the scan, read during emission
   always_ff @(posedge clock) begin
      if (occ_we) begin
         occ_mem[pend_i_ff] <= cnt_fin;
      end
      if (occ_re) begin
         occ_rd_ff <= occ_mem[e_ff[AW-1:0]];
      end
   end

   assign busy           = (state_ff != EV_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_mode_value = $signed(mode_v_ff);
   assign rsp_mode_count = mode_c_ff;
   assign rsp_max_value  = $signed(max_v_ff);
   assign rsp_max_count  = max_c_ff;
   assign rsp_overflow   = ovf_ff;
   assign rsp_last_res   = lres_ff;

endmodule

### design/set_max_and_mode_finder.sv
// Top level of the set maximum and mode finder.
// Depends on smmf_pkg, smmf_store and smmf_eval.
//
// Usage:
//   Input: present a word on req_value/req_last with start high; it is taken
//   at a rising edge where start is high and busy is low. Words of a set load
//   at one per cycle; req_last marks the final word of the set.
//   Words arriving once CAPACITY are stored are dropped and flagged in
//   rsp_overflow. A final word always starts an evaluation, dropped or not.
//   Output: one word per distinct mode, in order of first appearance, each
//   shown for one cycle with rsp_strobe high and carrying the maximum, its
//   count and the overflow flag. rsp_last_res marks the final mode word.
//   The receiver cannot stall; results must be taken as they appear.
//   Timing: busy rises after the final word and stays high through the
//   pairwise occurrence scan, paced by the single read port of the element
//   memory, followed by an emission pass. The last result word appears
//   no later than the first cycle with busy low; a new set may load then.
//   Reset: the store is emptied, the dropped-word flag cleared and any evaluation
//   abandoned; memory contents are left undefined.
module set_max_and_mode_finder
   import smmf_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_last,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_mode_value,
   output logic [COUNT_W-1:0]       rsp_mode_count,
   output logic signed [DATA_W-1:0] rsp_max_value,
   output logic [COUNT_W-1:0]       rsp_max_count,
   output logic                     rsp_overflow,
   output logic                     rsp_last_res
);

   store_ctl_type     store_ctl;
   logic              accept;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic [CW-1:0]     fill;
   logic              dropped;

   // take a word whenever start is high and the sequencer is idle
   assign accept = start && !busy;

   // element memory; written only while idle, read only while evaluating,
   // so the sequencer itself keeps loads and reads apart
   smmf_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (req_value),
      .ctl     (store_ctl),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .fill    (fill),
      .dropped (dropped)
   );

   // the final word kicks off the scan as it is taken, stored or dropped
   smmf_eval #(
      .CAPACITY (CAPACITY)
   ) u_eval (
      .clock          (clock),
      .reset          (reset),
      .go             (accept && req_last),
      .fill           (fill),
      .dropped        (dropped),
      .rd_data        (rd_data),
      .ctl            (store_ctl),
      .rd_addr        (rd_addr),
      .busy           (busy),
      .rsp_strobe     (rsp_strobe),
      .rsp_mode_value (rsp_mode_value),
      .rsp_mode_count (rsp_mode_count),
      .rsp_max_value  (rsp_max_value),
      .rsp_max_count  (rsp_max_count),
      .rsp_overflow   (rsp_overflow),
      .rsp_last_res   (rsp_last_res)
   );

   // a final word always starts an evaluation
   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last) |=> busy)
      else $error("final word did not start an evaluation");

   // results only come out of an evaluation
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result word without an evaluation");

   // nothing follows the word marked last
   a_last_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_res) |=> !rsp_strobe)
      else $error("result word after the final one");

endmodule
